// ===== src/icmp_echo_input_classifier_assert.svh =====
// Assertion macros for the ICMP echo input classifier.
// Expects clk_i and rst_ni in the scope of the file that includes it.
`ifndef ICMP_ECHO_INPUT_CLASSIFIER_ASSERT_SVH
`define ICMP_ECHO_INPUT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IEC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("iec: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define IEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iec: next-cycle check failed");

`endif

// ===== src/iec_pkg.sv =====
// Shared types and constants of the ICMP echo input classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package iec_pkg;

  // Result verdict codes
  typedef enum logic [1:0] {
    VERDICT_DROP       = 2'd0,
    VERDICT_IGNORE     = 2'd1,
    VERDICT_ECHO_REPLY = 2'd2,
    VERDICT_SEND_REPLY = 2'd3
  } verdict_e;

  // Configuration register indexes
  localparam logic CFG_ADDR_VALID = 1'b0;
  localparam logic CFG_OWN_ADDR   = 1'b1;

  // ICMP message types handled here
  localparam logic [7:0] ICMP_TYPE_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] ICMP_TYPE_ECHO_REQUEST = 8'd8;

  // Byte offsets within the message
  localparam int OFS_TYPE     = 0;
  localparam int OFS_CODE     = 1;
  localparam int OFS_CSUM_HI  = 2;
  localparam int OFS_CSUM_LO  = 3;
  localparam int OFS_IDENT_HI = 4;
  localparam int OFS_IDENT_LO = 5;
  localparam int OFS_SEQ_HI   = 6;
  localparam int OFS_SEQ_LO   = 7;

  // Minimum lengths
  localparam int MIN_ICMP_LEN = 4;
  localparam int MIN_ECHO_LEN = 8;

  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;

  // Summary of one finished message, handed from front to back
  typedef struct packed {
    logic [15:0] full_sum;
    logic [15:0] reply_sum;
    logic [7:0]  type_val;
    logic [7:0]  code_val;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [31:0] sender;
    logic [31:0] target;
    logic        short_icmp;  // fewer than 4 bytes
    logic        short_echo;  // fewer than 8 bytes
    logic        oversize;    // longer than the limit
  } msg_t;

endpackage

// ===== src/iec_front.sv =====
// Front end: takes message bytes, keeps the running sums and header fields.
// Depends on iec_pkg; emits one msg_t summary per final byte.
`timescale 1ns / 1ps

module iec_front import iec_pkg::*; #(
  parameter int MAX_MESSAGE_LEN = 1480,
  localparam int LenW = $clog2(MAX_MESSAGE_LEN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic [31:0]     sender_address_i,
  input  logic [31:0]     target_address_i,
  output logic            push_o,
  output msg_t            msg_o,
  output logic [LenW-1:0] len_o
);

  // Counter holds one past the limit once saturated
  localparam int CntW = $clog2(MAX_MESSAGE_LEN + 2);
  localparam logic [CntW-1:0] Limit = CntW'(MAX_MESSAGE_LEN);

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  logic [CntW-1:0] cnt_q, cnt_d, len;
  logic [15:0]     full_q, full_d, reply_q, reply_d;
  logic [7:0]      held_q, held_d, type_q, type_d, code_q, code_d;
  logic [15:0]     ident_q, ident_d, seq_q, seq_d;
  logic [15:0]     word_full, word_reply;
  logic            in_range, sum_en, odd, add_en, oversize;

  always_comb begin
    in_range = cnt_q <= Limit;
    sum_en   = cnt_q < Limit;
    odd      = cnt_q[0];
    len      = in_range ? cnt_q + CntW'(1) : cnt_q;

    // Odd offset closes a word; an even final byte is padded with zero.
    word_full = odd ? {held_q, data_byte_i} : {data_byte_i, 8'h00};
    if (odd) begin
      if (cnt_q == CntW'(OFS_CODE)) begin
        word_reply = {8'h00, data_byte_i};
      end else if (cnt_q == CntW'(OFS_CSUM_LO)) begin
        word_reply = 16'h0000;
      end else begin
        word_reply = word_full;
      end
    end else begin
      if (cnt_q == CntW'(OFS_TYPE) || cnt_q == CntW'(OFS_CSUM_HI)) begin
        word_reply = 16'h0000;
      end else begin
        word_reply = word_full;
      end
    end

    add_en  = sum_en && (odd || last_byte_i);
    full_d  = add_en ? oc_add(full_q, word_full) : full_q;
    reply_d = add_en ? oc_add(reply_q, word_reply) : reply_q;

    held_d  = (sum_en && !odd) ? data_byte_i : held_q;
    type_d  = (sum_en && cnt_q == CntW'(OFS_TYPE)) ? data_byte_i : type_q;
    code_d  = (sum_en && cnt_q == CntW'(OFS_CODE)) ? data_byte_i : code_q;
    ident_d = ident_q;
    seq_d   = seq_q;
    if (sum_en && cnt_q == CntW'(OFS_IDENT_HI)) ident_d[15:8] = data_byte_i;
    if (sum_en && cnt_q == CntW'(OFS_IDENT_LO)) ident_d[7:0]  = data_byte_i;
    if (sum_en && cnt_q == CntW'(OFS_SEQ_HI))   seq_d[15:8]   = data_byte_i;
    if (sum_en && cnt_q == CntW'(OFS_SEQ_LO))   seq_d[7:0]    = data_byte_i;

    cnt_d = last_byte_i ? '0 : len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      full_q  <= '0;
      reply_q <= '0;
    end else if (accept_i) begin
      cnt_q   <= cnt_d;
      full_q  <= last_byte_i ? 16'h0000 : full_d;
      reply_q <= last_byte_i ? 16'h0000 : reply_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q  <= held_d;
      type_q  <= type_d;
      code_q  <= code_d;
      ident_q <= ident_d;
      seq_q   <= seq_d;
    end
  end

  assign oversize = len > Limit;
  assign push_o   = accept_i && last_byte_i;
  assign len_o    = oversize ? LenW'(Limit) : LenW'(len);

  always_comb begin
    msg_o.full_sum   = full_d;
    msg_o.reply_sum  = reply_d;
    msg_o.type_val   = type_d;
    msg_o.code_val   = code_d;
    msg_o.ident      = ident_d;
    msg_o.seq        = seq_d;
    msg_o.sender     = sender_address_i;
    msg_o.target     = target_address_i;
    msg_o.short_icmp = len < CntW'(MIN_ICMP_LEN);
    msg_o.short_echo = len < CntW'(MIN_ECHO_LEN);
    msg_o.oversize   = oversize;
  end

endmodule

// ===== src/iec_queue.sv =====
// Two-entry queue between the front end and the verdict stage.
// Depends on iec_pkg only for house style; data is an opaque vector.
`timescale 1ns / 1ps

module iec_queue import iec_pkg::*; #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wptr_q, rptr_q;
  logic [1:0]        count_q;

  assign ready_o = count_q != 2'd2;
  assign valid_o = count_q != 2'd0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

// ===== src/iec_back.sv =====
// Verdict stage: classifies a queued message summary into the output register.
// Depends on iec_pkg (msg_t, verdict_e, type constants).
`timescale 1ns / 1ps

module iec_back import iec_pkg::*; #(
  parameter int LEN_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             addr_valid_i,
  input  logic [31:0]      own_address_i,
  input  logic             q_valid_i,
  input  msg_t             msg_i,
  input  logic [LEN_W-1:0] len_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output verdict_e         verdict_o,
  output logic [15:0]      ident_o,
  output logic [15:0]      seq_o,
  output logic [15:0]      csum_o,
  output logic [LEN_W-1:0] len_o,
  output logic [31:0]      peer_o
);

  verdict_e    verdict_d, verdict_q;
  logic [15:0] ident_d, seq_d, csum_d, ident_q, seq_q, csum_q;
  logic [LEN_W-1:0] len_q;
  logic [31:0] peer_q;
  logic        valid_q;
  logic        is_echo;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    is_echo = msg_i.type_val == ICMP_TYPE_ECHO_REQUEST ||
              msg_i.type_val == ICMP_TYPE_ECHO_REPLY;
    priority if (msg_i.short_icmp || msg_i.oversize || msg_i.full_sum != SUM_ALL_ONES) begin
      verdict_d = VERDICT_DROP;
    end else if (!is_echo) begin
      verdict_d = VERDICT_IGNORE;
    end else if (msg_i.code_val != 8'd0 || msg_i.short_echo) begin
      verdict_d = VERDICT_DROP;
    end else if (!addr_valid_i || msg_i.target != own_address_i) begin
      verdict_d = VERDICT_IGNORE;
    end else if (msg_i.type_val == ICMP_TYPE_ECHO_REPLY) begin
      verdict_d = VERDICT_ECHO_REPLY;
    end else begin
      verdict_d = VERDICT_SEND_REPLY;
    end

    if (verdict_d == VERDICT_ECHO_REPLY || verdict_d == VERDICT_SEND_REPLY) begin
      ident_d = msg_i.ident;
      seq_d   = msg_i.seq;
    end else begin
      ident_d = 16'h0000;
      seq_d   = 16'h0000;
    end
    csum_d = (verdict_d == VERDICT_SEND_REPLY) ? ~msg_i.reply_sum : 16'h0000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      ident_q   <= ident_d;
      seq_q     <= seq_d;
      csum_q    <= csum_d;
      len_q     <= len_i;
      peer_q    <= msg_i.sender;
    end
  end

  assign out_valid_o = valid_q;
  assign verdict_o   = verdict_q;
  assign ident_o     = ident_q;
  assign seq_o       = seq_q;
  assign csum_o      = csum_q;
  assign len_o       = len_q;
  assign peer_o      = peer_q;

endmodule

// ===== src/icmp_echo_input_classifier.sv =====
// Top level of the ICMP echo input classifier: config registers, front end,
// message queue and verdict stage. Depends on iec_pkg, iec_front, iec_queue, iec_back.
`timescale 1ns / 1ps

// Takes an ICMP message one byte per beat on the input channel, starting with
// the type byte, with last_byte_i high on the final beat. Byte beats are taken
// whenever in_ready_o is high, and a new message may start before the verdict of
// the last one is out, while the queue has space. The front end folds each byte
// into two RFC 1071 ones-complement sums (one whole, one with the type and
// checksum bytes as zero) with a single 16-bit end-around add per byte pair (or
// final lone byte), and captures type, code, identifier and sequence. On the final
// byte it pushes a message summary into a two-entry queue; the verdict stage pops
// it into the output register as the result beat. in_ready_o only drops while both
// queue entries are held behind a stalled output. One result beat per message:
// 0 drop, 1 ignored, 2 echo reply received (identifier and sequence given), 3 send
// echo reply (reply checksum for a type 0 reply given). Configuration (address_valid
// at index 0, own_address at index 1) is written with cfg_we_i; the user writes
// it only while the block is idle, which the block itself does not enforce.
module icmp_echo_input_classifier import iec_pkg::*; #(
  parameter int MAX_MESSAGE_LEN = 1480,
  localparam int LenW = $clog2(MAX_MESSAGE_LEN + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration write port
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [31:0]     cfg_wdata_i,
  // byte input channel
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_byte_i,
  input  logic [31:0]     sender_address_i,
  input  logic [31:0]     target_address_i,
  // result channel
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      verdict_o,
  output logic [15:0]     echo_identifier_o,
  output logic [15:0]     echo_sequence_o,
  output logic [15:0]     reply_checksum_o,
  output logic [LenW-1:0] message_length_o,
  output logic [31:0]     peer_address_o
);

  `include "icmp_echo_input_classifier_assert.svh"

  localparam int QDataW = $bits(msg_t) + LenW;

  logic             addr_valid_q;
  logic [31:0]      own_addr_q;
  logic             in_accept;
  logic             push, pop, q_ready, q_valid;
  msg_t             front_msg;
  logic [LenW-1:0]  front_len;
  logic [QDataW-1:0] q_wdata, q_rdata;
  msg_t             back_msg;
  logic [LenW-1:0]  back_len;
  verdict_e         verdict;
  logic             is_send, no_echo_verdict, echo_fields_zero;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_valid_q <= 1'b0;
      own_addr_q   <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_VALID: addr_valid_q <= cfg_wdata_i[0];
        CFG_OWN_ADDR:   own_addr_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Non-final bytes never push, but keep the gate simple: space in the queue
  assign in_ready_o = q_ready;
  assign in_accept  = in_valid_i && q_ready;

  iec_front #(
    .MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (in_accept),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .sender_address_i(sender_address_i),
    .target_address_i(target_address_i),
    .push_o          (push),
    .msg_o           (front_msg),
    .len_o           (front_len)
  );

  assign q_wdata = {front_len, front_msg};

  iec_queue #(
    .DATA_W(QDataW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(q_wdata),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  assign back_msg = q_rdata[$bits(msg_t)-1:0];
  assign back_len = q_rdata[QDataW-1:$bits(msg_t)];

  iec_back #(
    .LEN_W(LenW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .addr_valid_i (addr_valid_q),
    .own_address_i(own_addr_q),
    .q_valid_i    (q_valid),
    .msg_i        (back_msg),
    .len_i        (back_len),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .verdict_o    (verdict),
    .ident_o      (echo_identifier_o),
    .seq_o        (echo_sequence_o),
    .csum_o       (reply_checksum_o),
    .len_o        (message_length_o),
    .peer_o       (peer_address_o)
  );

  assign verdict_o = verdict;

  assign is_send          = verdict == VERDICT_SEND_REPLY;
  assign no_echo_verdict  = verdict == VERDICT_DROP || verdict == VERDICT_IGNORE;
  assign echo_fields_zero = (echo_identifier_o | echo_sequence_o) == 16'h0000;

  // A byte that is not the last one must never create a queued message.
  `IEC_ASSERT_NEXT(a_no_push_mid_message, in_accept && !last_byte_i && !q_valid, !q_valid)
  // Reply checksum only carries a value for the send-reply verdict.
  `IEC_ASSERT_IMPLIES(a_csum_only_on_send, out_valid_o && !is_send, reply_checksum_o == 16'h0000)
  // Identifier and sequence are zero for drop and ignore verdicts.
  `IEC_ASSERT_IMPLIES(a_echo_fields_zero, out_valid_o && no_echo_verdict, echo_fields_zero)
  // Reported length never exceeds the limit.
  `IEC_ASSERT_IMPLIES(a_len_clipped, out_valid_o, message_length_o <= LenW'(MAX_MESSAGE_LEN))

endmodule
